// File: sv/ple_pkg.sv
// ple_pkg: shared constants, op codes and cell control type for the positional list engine
// no dependencies
package ple_pkg;

  localparam int DEPTH     = 64;
  localparam int CODE_BITS = 32;

  // fixed field widths of the request and response channels
  localparam int OP_W   = 2;
  localparam int POS_W  = 7;
  localparam int WORD_W = 32;
  localparam int LEN_W  = 7;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  // compare width wide enough for position, count and count + 1
  localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  // read-back reduction: groups of cells ored and registered, then groups ored
  localparam int GRP  = 8;
  localparam int NGRP = (DEPTH + GRP - 1) / GRP;

  typedef enum logic [OP_W-1:0] {
    OP_RETRIEVE = 2'd0,
    OP_INSERT   = 2'd1,
    OP_REMOVE   = 2'd2
  } op_t;

  typedef struct packed {
    logic                 ins;
    logic                 del;
    logic [IDX_W-1:0]     pos;
    logic [CODE_BITS-1:0] code;
  } cell_ctrl_t;

endpackage

// File: sv/ple_req_if.sv
// ple_req_if: request channel (valid/ready plus op, position, code word)
// depends on ple_pkg for field widths
interface ple_req_if import ple_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic        [OP_W-1:0]   op;
  logic        [POS_W-1:0]  position;
  logic signed [WORD_W-1:0] code_in;

  modport source (output valid, output op, output position, output code_in, input ready);
  modport sink   (input valid, input op, input position, input code_in, output ready);
endinterface

// File: sv/ple_rsp_if.sv
// ple_rsp_if: response channel (valid/ready plus ok, code word, list length)
// depends on ple_pkg for field widths
interface ple_rsp_if import ple_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic signed [WORD_W-1:0] code_out;
  logic        [LEN_W-1:0]  list_length;

  modport source (output valid, output ok, output code_out, output list_length, input ready);
  modport sink   (input valid, input ok, input code_out, input list_length, output ready);
endinterface

// File: sv/ple_cell.sv
// ple_cell: one list entry; shifts from its left or right neighbor or loads a new word
// depends on ple_pkg for the control struct and widths
module ple_cell import ple_pkg::*; (
  input  logic                 clk,
  input  logic [IDX_W-1:0]     idx,
  input  cell_ctrl_t           ctrl,
  input  logic [CODE_BITS-1:0] left_data,
  input  logic [CODE_BITS-1:0] right_data,
  output logic [CODE_BITS-1:0] data,
  output logic [CODE_BITS-1:0] rd_data
);

  logic [CODE_BITS-1:0] data_r;

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (idx > ctrl.pos) begin
        data_r <= left_data;
      end else if (idx == ctrl.pos) begin
        data_r <= ctrl.code;
      end
    end else if (ctrl.del) begin
      if (idx >= ctrl.pos) begin
        data_r <= right_data;
      end
    end
  end

  assign data    = data_r;
  // only the addressed cell drives the read-back or
  assign rd_data = (idx == ctrl.pos) ? data_r : '0;

endmodule

// File: sv/positional_list_engine.sv
// positional_list_engine: ordered list of DEPTH words kept in a row of shifting cells
// flow: S_EXEC shifts the cells and registers the read-back or groups, then S_DONE
// loads the result (held while the response stalls); no new request is taken until then
// reset: rst_n synchronous active low clears length and handshake state; cell words are
// left as they are, only positions 1..length are ever read
module positional_list_engine import ple_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  ple_req_if.sink   in_req,
  ple_rsp_if.source out_rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_t;

  state_t               state_r;
  logic [CNT_W-1:0]     count_r;
  logic                 ok_r;
  logic                 rd_r;
  logic                 ins_r;
  logic                 del_r;
  logic [IDX_W-1:0]     pos_r;
  logic [CODE_BITS-1:0] code_r;
  logic [CODE_BITS-1:0] grp_r [NGRP];

  logic                 out_valid_r;
  logic                 out_ok_r;
  logic [WORD_W-1:0]    out_code_r;
  logic [LEN_W-1:0]     out_len_r;

  // request decode
  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] cnt_x;
  logic             in_range;
  logic             ok_dec;
  logic             out_free;

  always_comb begin
    pos_x    = CMP_W'(in_req.position);
    cnt_x    = CMP_W'(count_r);
    in_range = (pos_x != '0) && (pos_x <= cnt_x);
    case (in_req.op)
      OP_RETRIEVE: ok_dec = in_range;
      OP_INSERT:   ok_dec = (cnt_x < CMP_W'(DEPTH)) && (pos_x != '0) &&
                            (pos_x <= cnt_x + CMP_W'(1));
      OP_REMOVE:   ok_dec = in_range;
      default:     ok_dec = 1'b0;
    endcase
  end

  assign out_free = !out_valid_r || out_rsp.ready;

  // cell row
  cell_ctrl_t           ctrl;
  logic [CODE_BITS-1:0] cell_data [DEPTH];
  logic [CODE_BITS-1:0] cell_rd   [DEPTH];

  always_comb begin
    ctrl.ins  = (state_r == S_EXEC) && ins_r;
    ctrl.del  = (state_r == S_EXEC) && del_r;
    ctrl.pos  = pos_r;
    ctrl.code = code_r;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [CODE_BITS-1:0] left_w;
    logic [CODE_BITS-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end
    ple_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(i)),
      .ctrl       (ctrl),
      .left_data  (left_w),
      .right_data (right_w),
      .data       (cell_data[i]),
      .rd_data    (cell_rd[i])
    );
  end

  // first read-back level: or within each group of cells
  logic [CODE_BITS-1:0] grp_nxt [NGRP];

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    always_comb begin
      grp_nxt[g] = '0;
      for (int j = 0; j < GRP; j++) begin
        if (g * GRP + j < DEPTH) begin
          grp_nxt[g] = grp_nxt[g] | cell_rd[g * GRP + j];
        end
      end
    end
  end

  // second level: or across the registered groups
  logic [CODE_BITS-1:0] rd_word;

  always_comb begin
    rd_word = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_word = rd_word | grp_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      ins_r       <= 1'b0;
      del_r       <= 1'b0;
    end else begin
      // in S_DONE a free output register is reloaded below
      if (out_valid_r && out_rsp.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_req.valid) begin
            ok_r    <= ok_dec;
            rd_r    <= (in_req.op == OP_RETRIEVE);
            ins_r   <= ok_dec && (in_req.op == OP_INSERT);
            del_r   <= ok_dec && (in_req.op == OP_REMOVE);
            pos_r   <= IDX_W'(in_req.position - POS_W'(1));
            code_r  <= CODE_BITS'($unsigned(in_req.code_in));
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          for (int g = 0; g < NGRP; g++) begin
            grp_r[g] <= grp_nxt[g];
          end
          if (ins_r) begin
            count_r <= count_r + CNT_W'(1);
          end else if (del_r) begin
            count_r <= count_r - CNT_W'(1);
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_ok_r    <= ok_r;
            out_code_r  <= (ok_r && rd_r) ? WORD_W'(rd_word) : '0;
            out_len_r   <= LEN_W'(count_r);
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_req.ready        = (state_r == S_IDLE);
  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.ok          = out_ok_r;
  assign out_rsp.code_out    = $signed(out_code_r);
  assign out_rsp.list_length = out_len_r;

  // length never runs past the row of cells
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("list length above depth");

  // a successful insert grows the list by exactly one
  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && ins_r) |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow list by one");

  // rejected requests carry no code word
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ok_r) |-> out_code_r == '0)
    else $error("failed response with nonzero code");

endmodule
